// File: src/brs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and fixed widths for the bicubic RGB24 resampler.
// ----------------------------------------------------------------------------
package brs_pkg;

  // source frame store limits, tied to the source size register width
  localparam int SRC_MAX_WIDTH  = 256;
  localparam int SRC_MAX_HEIGHT = 256;

  localparam int DEST_W = 12;  // column / row field width
  localparam int SW_W   = 9;   // source size register width
  localparam int DEN_W  = 13;  // target size register width
  localparam int CFG_W  = 13;  // widest register
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_SRC_W = 2'd0;
  localparam logic [IDX_W-1:0] REG_SRC_H = 2'd1;
  localparam logic [IDX_W-1:0] REG_DST_W = 2'd2;
  localparam logic [IDX_W-1:0] REG_DST_H = 2'd3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIVX = 6'b000010,
    S_DIVY = 6'b000100,
    S_KERN = 6'b001000,
    S_MAC  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

// File: src/brs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_in_if
// Input channel: load or request item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] column;
  logic [11:0] row;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;

  modport source (output valid, cmd, column, row, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, column, row, red_in, green_in, blue_in, output ready);
endinterface

// File: src/brs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_out_if
// Output channel: one interpolated RGB pixel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: src/bicubic_resize_rgb24.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_resize_rgb24
// Bicubic (a = -1) RGB24 resampler with an on-chip source frame store.
// ----------------------------------------------------------------------------
// pixel_in carries items: cmd 0 writes one source pixel into the frame store,
// cmd 1 asks for the destination pixel at (column, row). pixel_out returns
// one RGB pixel for each request and nothing for a load.
// A load is written into the frame store as it is accepted, and the block
// stays ready. For a request, the serial divider maps column then row at one
// quotient bit a cycle, the kernel unit evaluates eight axis weights one after
// another, and the multiply-accumulate walks the sixteen taps at one frame
// memory read a cycle, then drains its pipe; the result then loads into the
// output register.
// pixel_in.ready is low while a request runs.
// The finished pixel sits in an output register; the block takes new items
// while it waits, but a following request cannot finish until the receiver
// takes it. Configuration is written through wr_en / wr_index / wr_data.
// Reset sets all four sizes to 256 and empties the output; the frame store
// is not cleared, and a request must only read pixels already loaded.
// ----------------------------------------------------------------------------
module bicubic_resize_rgb24
  import brs_pkg::*;
#(
  parameter int FRAC_BITS      = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  brs_in_if.sink           pixel_in,
  brs_out_if.source        pixel_out
);
  localparam int NUM_W  = DEST_W + FRAC_BITS + SW_W;
  localparam int IP_W   = NUM_W - FRAC_BITS;
  localparam int W_W    = FRAC_BITS + 3;
  localparam int W2_W   = 2 * W_W;
  localparam int ACC_W  = 2 * FRAC_BITS + 16;
  localparam int MEM_D  = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int MEM_AW = $clog2(MEM_D);

  state_t state;

  logic [SW_W-1:0]  src_w_cfg, src_h_cfg;
  logic [DEN_W-1:0] dst_w_cfg, dst_h_cfg;
  logic [SW_W-1:0]  sw, sh;
  logic [DEN_W-1:0] tw, th;

  logic [DEST_W-1:0] dest_row;
  logic [NUM_W-1:0]  px, py;
  logic [SW_W-1:0]   bx, by;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;

  logic             k_start, k_done, k_wait;
  logic [2:0]       kidx;
  logic [SW_W-1:0]  k_tap;
  logic [NUM_W-1:0] k_pos;
  logic signed [W_W-1:0] k_w;
  logic signed [W_W-1:0] wx [4];
  logic signed [W_W-1:0] wy [4];

  logic [4:0]  cnt;
  logic        v1, v2;
  logic signed [W2_W-1:0]  w2;
  logic signed [ACC_W-1:0] prod [3];
  logic signed [ACC_W-1:0] acc  [3];
  logic [SW_W-1:0] ty, tx;

  logic [23:0]       frame [MEM_D];
  logic [23:0]       mem_q;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] waddr, raddr;

  logic        in_acc, out_load;
  logic [7:0]  ch [3];

  function automatic logic [SW_W-1:0] clamp_src(input logic [SW_W-1:0] v, input int mx);
    if (v < SW_W'(4)) return SW_W'(4);
    if (32'(v) > mx) return SW_W'(mx);
    return v;
  endfunction

  function automatic logic [SW_W-1:0] clamp_base(input logic [NUM_W-1:0] p,
                                                 input logic [SW_W-1:0] s);
    logic [IP_W-1:0] ip;
    ip = p[NUM_W-1:FRAC_BITS];
    if (ip == '0) return SW_W'(1);
    if (ip > IP_W'(s - SW_W'(3))) return s - SW_W'(3);
    return ip[SW_W-1:0];
  endfunction

  function automatic logic [7:0] finish_ch(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + (ACC_W'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    if (a < 0) return 8'd0;
    if (r > ACC_W'(255)) return 8'd255;
    return r[7:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w_cfg <= SW_W'(256);
      src_h_cfg <= SW_W'(256);
      dst_w_cfg <= DEN_W'(256);
      dst_h_cfg <= DEN_W'(256);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SRC_W: src_w_cfg <= wr_data[SW_W-1:0];
        REG_SRC_H: src_h_cfg <= wr_data[SW_W-1:0];
        REG_DST_W: dst_w_cfg <= wr_data;
        REG_DST_H: dst_h_cfg <= wr_data;
        default: ;
      endcase
    end
  end

  assign sw = clamp_src(src_w_cfg, SRC_MAX_WIDTH);
  assign sh = clamp_src(src_h_cfg, SRC_MAX_HEIGHT);
  assign tw = (dst_w_cfg == '0) ? DEN_W'(1) : dst_w_cfg;
  assign th = (dst_h_cfg == '0) ? DEN_W'(1) : dst_h_cfg;

  assign pixel_in.ready = (state == S_IDLE);
  assign in_acc = pixel_in.valid && pixel_in.ready;

  // divider feeds: column at the accept, row once column is done
  assign div_start = (in_acc && pixel_in.cmd == CMD_REQUEST) || (state == S_DIVX && div_done);
  assign div_num = (state == S_IDLE)
                 ? (NUM_W'(pixel_in.column) << FRAC_BITS) * NUM_W'(sw)
                 : (NUM_W'(dest_row) << FRAC_BITS) * NUM_W'(sh);
  assign div_den = (state == S_IDLE) ? tw : th;

  brs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  // axis weights: four x taps, then four y taps
  assign k_start = (state == S_KERN) && !k_wait;
  assign k_tap   = (kidx[2] ? by : bx) - SW_W'(1) + SW_W'(kidx[1:0]);
  assign k_pos   = kidx[2] ? py : px;

  brs_kernel #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W), .TAP_W(SW_W)) u_kern (
    .clk(clk), .rst(rst), .start(k_start), .tap(k_tap), .pos(k_pos),
    .done(k_done), .weight(k_w)
  );

  // frame store
  assign ty     = by - SW_W'(1) + SW_W'(cnt[3:2]);
  assign tx     = bx - SW_W'(1) + SW_W'(cnt[1:0]);
  assign mem_re = (state == S_MAC) && !cnt[4];
  assign raddr  = MEM_AW'(ty) * MEM_AW'(SRC_MAX_WIDTH) + MEM_AW'(tx);
  assign mem_we = in_acc && pixel_in.cmd == CMD_LOAD
               && 32'(pixel_in.column) < SRC_MAX_WIDTH
               && 32'(pixel_in.row) < SRC_MAX_HEIGHT;
  assign waddr  = MEM_AW'(pixel_in.row) * MEM_AW'(SRC_MAX_WIDTH) + MEM_AW'(pixel_in.column);

  always_ff @(posedge clk) begin
    if (mem_we) frame[waddr] <= {pixel_in.red_in, pixel_in.green_in, pixel_in.blue_in};
    if (mem_re) mem_q <= frame[raddr];
  end

  assign out_load = (state == S_DONE) && (!pixel_out.valid || pixel_out.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      k_wait <= 1'b0;
      kidx   <= '0;
      cnt    <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else begin
      v1 <= mem_re;
      v2 <= v1;
      unique case (state)
        S_IDLE: if (in_acc && pixel_in.cmd == CMD_REQUEST) state <= S_DIVX;
        S_DIVX: if (div_done) state <= S_DIVY;
        S_DIVY: if (div_done) begin
          state <= S_KERN;
          kidx  <= '0;
        end
        S_KERN: begin
          if (k_start) k_wait <= 1'b1;
          if (k_done) begin
            k_wait <= 1'b0;
            kidx   <= kidx + 1'b1;
            if (kidx == 3'd7) begin
              state <= S_MAC;
              cnt   <= '0;
            end
          end
        end
        S_MAC: begin
          if (!cnt[4]) cnt <= cnt + 1'b1;
          else if (!v1 && !v2) state <= S_DONE;
        end
        S_DONE: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) dest_row <= pixel_in.row;
    if (state == S_DIVX && div_done) begin
      px <= div_quot;
      bx <= clamp_base(div_quot, sw);
    end
    if (state == S_DIVY && div_done) begin
      py <= div_quot;
      by <= clamp_base(div_quot, sh);
    end
    if (state == S_KERN && k_done) begin
      if (kidx[2]) wy[kidx[1:0]] <= k_w;
      else wx[kidx[1:0]] <= k_w;
    end
    if (mem_re) w2 <= W2_W'(wx[cnt[1:0]]) * W2_W'(wy[cnt[3:2]]);
    for (int c = 0; c < 3; c++) begin
      if (v1) prod[c] <= ACC_W'(w2) * $signed({1'b0, mem_q[23-8*c -: 8]});
      if (state == S_DIVX) acc[c] <= '0;
      else if (v2) acc[c] <= acc[c] + prod[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) ch[c] = finish_ch(acc[c]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (out_load) begin
      pixel_out.valid <= 1'b1;
    end else if (pixel_out.ready) begin
      pixel_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out.red_out   <= ch[0];
      pixel_out.green_out <= ch[1];
      pixel_out.blue_out  <= ch[2];
    end
  end
endmodule

// File: src/brs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brs_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quot[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end
endmodule

// File: src/brs_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_kernel
// Cubic kernel weight for one tap; the square and the cube each form in a registered stage of their own.
// ----------------------------------------------------------------------------
module brs_kernel #(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W     = 37,
  parameter int TAP_W     = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [TAP_W-1:0]            tap,
  input  logic [NUM_W-1:0]            pos,
  output logic                        done,
  output logic signed [FRAC_BITS+2:0] weight
);
  localparam int D_W  = FRAC_BITS + 2;
  localparam int D2_W = FRAC_BITS + 3;
  localparam int D3_W = FRAC_BITS + 4;
  localparam int K_W  = FRAC_BITS + 8;
  localparam int W_W  = FRAC_BITS + 3;

  logic [NUM_W:0]   tp;
  logic [NUM_W:0]   tap_dist;
  logic [D_W-1:0]   d;
  logic [D2_W-1:0]  d2;
  logic [D3_W-1:0]  d3;
  logic             far1, far2, far3;
  logic [2:0]       vld;
  logic [2*D_W-1:0]     sq;
  logic [D2_W+D_W-1:0]  cu;
  logic signed [K_W-1:0] one, sd, sd2, sd3, wk;

  assign tp       = (NUM_W + 1)'(tap) << FRAC_BITS;
  assign tap_dist = (tp >= {1'b0, pos}) ? tp - {1'b0, pos} : {1'b0, pos} - tp;
  assign sq   = d * d;
  assign cu   = d2 * d;

  assign one = K_W'(1) <<< FRAC_BITS;
  assign sd  = K_W'(d);
  assign sd2 = K_W'(d2);
  assign sd3 = K_W'(d3);

  always_comb begin
    if (far3) wk = '0;
    else if (sd <= one) wk = K_W'(one - 2 * sd2 + sd3);
    else wk = K_W'(4 * one - 8 * sd + 5 * sd2 - sd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], start};
      done <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      far1 <= tap_dist > ((NUM_W + 1)'(2) << FRAC_BITS);
      d    <= tap_dist[D_W-1:0];
    end
    d2     <= D2_W'(sq >> FRAC_BITS);
    far2   <= far1;
    d3     <= D3_W'(cu >> FRAC_BITS);
    far3   <= far2;
    weight <= W_W'(wk);
  end
endmodule

// File: src/brs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks for the bicubic resampler, bound to the top level.
// ----------------------------------------------------------------------------
module brs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);
  // a request keeps the block busy
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd |=> !in_ready)
    else $error("ready after request item");

  // a load leaves the block ready
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_cmd |=> in_ready)
    else $error("busy after load item");

  // a new result only appears at the end of a request
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out)
                                && $stable(green_out) && $stable(blue_out))
    else $error("stalled result changed");
endmodule

bind bicubic_resize_rgb24 brs_checker u_brs_checker (
  .clk(clk), .rst(rst),
  .in_valid(pixel_in.valid), .in_ready(pixel_in.ready), .in_cmd(pixel_in.cmd),
  .out_valid(pixel_out.valid), .out_ready(pixel_out.ready),
  .red_out(pixel_out.red_out), .green_out(pixel_out.green_out),
  .blue_out(pixel_out.blue_out)
);
